// ===== rtl/sdc_pkg.sv =====
// Shared types and constants for the segment deframer with checksum check.
// Used by sdc_core, sdc_out and segment_deframer_checksum_check_top.
package sdc_pkg;

	// Segment size in bytes and derived widths
	localparam int SEG_BYTES = 2048;
	localparam int CNT_W     = $clog2(SEG_BYTES + 1);
	localparam int SUM_W     = 16 + $clog2(SEG_BYTES / 2 + 1);
	localparam int OFF_W     = 11;

	// Framing characters
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;

	// Input item kind
	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_CLOSE = 1'b1;

	// Result kind
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Frame status codes
	localparam logic [1:0] ST_GOOD   = 2'd0;
	localparam logic [1:0] ST_BADSUM = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;
	localparam logic [1:0] ST_OVFL   = 2'd3;

	typedef enum logic [1:0] {
		HUNT1 = 2'd0,
		HUNT2 = 2'd1,
		RECV  = 2'd2,
		STOP1 = 2'd3
	} hunt_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [OFF_W-1:0] offset;
		logic [1:0]       status;
		logic             last;
	} result_t;

	// Up to two results per input item
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

endpackage

// ===== rtl/sdc_core.sv =====
// Framing state machine, payload offset counter and ones-complement sum.
// Depends on sdc_pkg.
module sdc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               action,
	input  logic [7:0]         byte_in,
	output sdc_pkg::res_pair_t pair
);
	import sdc_pkg::*;

	hunt_t            hunt_q, hunt_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt1;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic             ovf_q, ovf_d;

	logic             want0, want1, full0, full1, take0, take1;
	logic [7:0]       pb0, pb1;
	logic [15:0]      w0, w1;
	logic             is_status, clear;
	logic [1:0]       st_code;
	logic [16:0]      fold;
	logic [15:0]      folded;
	result_t          p0, p1, st_res;

	// Next hunt state
	always_comb begin
		hunt_d = hunt_q;
		if (action == ACT_CLOSE) begin
			hunt_d = HUNT1;
		end else begin
			case (hunt_q)
				HUNT1: if (byte_in == CH_BANG) hunt_d = HUNT2;
				HUNT2: hunt_d = (byte_in == CH_AMP) ? RECV : HUNT1;
				RECV:  if (byte_in == CH_BANG) hunt_d = STOP1;
				STOP1: hunt_d = (byte_in == CH_HASH) ? HUNT1 : RECV;
				default: hunt_d = HUNT1;
			endcase
		end
	end

	// Checksum fold: end-around carry, good when all ones; overflow takes priority
	always_comb begin
		fold   = {1'b0, sum_q[15:0]} + 17'(sum_q[SUM_W-1:16]);
		folded = fold[15:0] + {15'd0, fold[16]};
		if (ovf_q)
			st_code = ST_OVFL;
		else if (folded == 16'hFFFF)
			st_code = ST_GOOD;
		else
			st_code = ST_BADSUM;
	end

	// Payload takes, results and state datapath
	always_comb begin
		want0     = 1'b0;
		want1     = 1'b0;
		pb0       = byte_in;
		pb1       = byte_in;
		is_status = 1'b0;
		clear     = 1'b0;
		st_res    = '0;
		st_res.kind = KIND_STATUS;

		if (action == ACT_CLOSE) begin
			is_status     = 1'b1;
			clear         = 1'b1;
			st_res.status = ST_CLOSED;
		end else begin
			case (hunt_q)
				HUNT2: clear = (byte_in == CH_AMP);
				RECV:  want0 = (byte_in != CH_BANG);
				STOP1: begin
					if (byte_in == CH_HASH) begin
						is_status     = 1'b1;
						clear         = 1'b1;
						st_res.status = st_code;
					end else begin
						want0 = 1'b1;
						pb0   = CH_BANG;
						want1 = 1'b1;
					end
				end
				default: ;
			endcase
		end

		full0 = (cnt_q >= CNT_W'(SEG_BYTES));
		take0 = want0 && !full0;
		cnt1  = cnt_q + CNT_W'(take0);
		full1 = (cnt1 >= CNT_W'(SEG_BYTES));
		take1 = want1 && !full1;

		w0 = !take0 ? 16'd0 : (cnt_q[0] ? {pb0, 8'd0} : {8'd0, pb0});
		w1 = !take1 ? 16'd0 : (cnt1[0]  ? {pb1, 8'd0} : {8'd0, pb1});

		p0 = '{kind: KIND_PAYLOAD, data: pb0, offset: OFF_W'(cnt_q),
			status: ST_GOOD, last: 1'b0};
		p1 = '{kind: KIND_PAYLOAD, data: pb1, offset: OFF_W'(cnt1),
			status: ST_GOOD, last: 1'b0};

		if (clear) begin
			cnt_d = '0;
			sum_d = '0;
			ovf_d = 1'b0;
		end else begin
			cnt_d = cnt1 + CNT_W'(take1);
			sum_d = sum_q + SUM_W'(w0) + SUM_W'(w1);
			ovf_d = ovf_q | (want0 & full0) | (want1 & full1);
		end

		// Pack results, mark the final one
		pair = '0;
		if (is_status) begin
			pair.count   = 2'd1;
			pair.r0      = st_res;
			pair.r0.last = 1'b1;
		end else if (take0 && take1) begin
			pair.count   = 2'd2;
			pair.r0      = p0;
			pair.r1      = p1;
			pair.r1.last = 1'b1;
		end else if (take0) begin
			pair.count   = 2'd1;
			pair.r0      = p0;
			pair.r0.last = 1'b1;
		end else if (take1) begin
			pair.count   = 2'd1;
			pair.r0      = p1;
			pair.r0.last = 1'b1;
		end
	end

	// State registers advance once per consumed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q <= HUNT1;
			cnt_q  <= '0;
			sum_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (step) begin
			hunt_q <= hunt_d;
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

// ===== rtl/sdc_out.sv =====
// Result register holding up to two results, handed out one per transaction.
// Depends on sdc_pkg.
module sdc_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sdc_pkg::res_pair_t pair,
	output logic               can_load,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [23:0]        m_axis_tdata,  // data_byte[7:0], byte_offset[18:8], status[20:19]
	output logic               m_axis_tuser,  // result_kind
	output logic               m_axis_tlast
);
	import sdc_pkg::*;

	result_t    res0_q, res1_q, cur;
	logic [1:0] rem_q;
	logic       head_q;
	logic       fire;

	assign cur           = head_q ? res1_q : res0_q;
	assign m_axis_tvalid = (rem_q != 2'd0);
	assign fire          = m_axis_tvalid && m_axis_tready;
	assign can_load      = (rem_q == 2'd0) || (rem_q == 2'd1 && m_axis_tready);

	assign m_axis_tdata  = {3'd0, cur.status, cur.offset, cur.data};
	assign m_axis_tuser  = cur.kind;
	assign m_axis_tlast  = cur.last;

	// Result payload
	always_ff @(posedge clk) begin
		if (load && pair.count != 2'd0) begin
			res0_q <= pair.r0;
			res1_q <= pair.r1;
		end
	end

	// Remaining count and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (load && pair.count != 2'd0) begin
			rem_q  <= pair.count;
			head_q <= 1'b0;
		end else if (fire) begin
			rem_q  <= rem_q - 2'd1;
			head_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/segment_deframer_checksum_check_top.sv =====
// Channel   Dir  tdata                                      tuser        tlast
// s_axis    in   byte_value[7:0]                            action       -
// m_axis    out  data_byte[7:0] offset[18:8] status[20:19]  result_kind  last
//
// An item waits in the input register, then is decoded and its
// results (zero, one or two) land in the result register in the same step.
// One item per cycle while m_axis is ready and each gives at most one result;
// an escaped pair holds the next item while the result register drains.
// arst_n clears the hunt state, offset counter, sum and all valid flags.
// Backpressure on m_axis stalls the input register and drops s_axis_tready.
//
// Top level of the segment deframer with checksum check.
// Depends on sdc_pkg, sdc_core and sdc_out.
module segment_deframer_checksum_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_value
	input  logic        s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // data_byte[7:0], byte_offset[18:8], status[20:19]
	output logic        m_axis_tuser,   // result_kind
	output logic        m_axis_tlast
);
	import sdc_pkg::*;

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       can_load, adv;
	res_pair_t  pair;

	assign adv           = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			byte_s1   <= s_axis_tdata;
		end
	end

	sdc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.action  (action_s1),
		.byte_in (byte_s1),
		.pair    (pair)
	);

	sdc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv),
		.pair          (pair),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
